>>> rtl/core/abst_pkg.sv
// Shared types and fixed constants of the adaptive block size tuner.
`default_nettype none

package abst_pkg;

	localparam int SIZE_W = 32;
	localparam int OFF_W  = 20;
	localparam int CUR_W  = 5;
	localparam int LVL_W  = 6;
	localparam int CNT_W  = 7;
	localparam int SA_W   = 16;
	localparam int EL_W   = 7;
	localparam int PI_W   = 16;
	localparam int CFG_W  = 16;
	localparam int CFG_AW = 1;

	localparam logic [CNT_W-1:0] ERROR_LIMIT_RST    = CNT_W'(32);
	localparam logic [PI_W-1:0]  PROBE_INTERVAL_RST = PI_W'(32);

	typedef enum logic [CFG_AW-1:0] {
		REG_ERROR_LIMIT    = 1'b0,
		REG_PROBE_INTERVAL = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_BUSY = 1'b1
	} state_t;

	localparam logic FUNC_REPORT = 1'b0;
	localparam logic FUNC_SIZE   = 1'b1;

	// level chosen for an item and whether it touches the level memory
	typedef struct packed {
		logic [LVL_W-1:0] lvl;
		logic             hit;
		logic             rej;
	} dec_t;

	// outcome of the update step
	typedef struct packed {
		logic              wr;
		logic [CUR_W-1:0]  level;
		logic [SIZE_W-1:0] block_size;
		logic              rejected;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/core/abst_mem.sv
// Level state memory: one entry per level, synchronous read, valid bits for reset.
`default_nettype none

module abst_mem #(
	parameter int DEPTH = 9,
	parameter int WIDTH = 93,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// an entry never written reads as the reset value
		if (re) begin
			rdata_q <= valid_q[raddr] ? mem_q[raddr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/abst_decode.sv
// Level selection for an incoming item, ahead of the memory read.
`default_nettype none

module abst_decode #(
	parameter int MIN_LEVEL = 12,
	parameter int MAX_LEVEL = 20
) (
	input  wire logic                       func,
	input  wire logic [abst_pkg::SIZE_W-1:0] size,
	input  wire logic [abst_pkg::OFF_W-1:0]  offset_low,
	input  wire logic [abst_pkg::CUR_W-1:0]  level_now,
	output abst_pkg::dec_t                  dec
);

	logic [31:0]                  ge;
	logic [31:0]                  first;
	logic [abst_pkg::LVL_W-1:0]   rep_lvl;
	logic                         rep_rej;
	logic [31:0]                  offx;
	logic [31:0]                  mis;
	logic [31:0]                  low;
	logic [abst_pkg::LVL_W-1:0]   low_lvl;
	logic [abst_pkg::LVL_W-1:0]   szl;
	logic [abst_pkg::LVL_W-1:0]   bsel;
	logic                         sz_hit;

	// report: 2^L >= size is monotonic in L, so the first true level is the edge
	always_comb begin
		ge      = '0;
		rep_lvl = '0;
		for (int l = 0; l < 32; l++) begin
			if (l >= MIN_LEVEL && l <= MAX_LEVEL) begin
				ge[l] = ({1'b0, size} <= (33'd1 << l));
			end
		end
		first = ge & ~{ge[30:0], 1'b0};
		for (int l = 0; l < 32; l++) begin
			if (first[l]) begin
				rep_lvl = rep_lvl | abst_pkg::LVL_W'(l);
			end
		end
		rep_rej = !ge[MAX_LEVEL];
	end

	// size: lowest level whose alignment bit is set caps the level
	always_comb begin
		offx    = {{(32 - abst_pkg::OFF_W){1'b0}}, offset_low};
		mis     = '0;
		low_lvl = '0;
		for (int l = 1; l < 32; l++) begin
			if (l >= MIN_LEVEL && l <= int'(level_now)) begin
				mis[l] = offx[l-1];
			end
		end
		low = mis & (~mis + 32'd1);
		for (int l = 0; l < 32; l++) begin
			if (low[l]) begin
				low_lvl = low_lvl | abst_pkg::LVL_W'(l);
			end
		end
		if (mis != '0) begin
			szl = low_lvl;
		end else if (int'(level_now) < MIN_LEVEL) begin
			szl = abst_pkg::LVL_W'(MIN_LEVEL);
		end else begin
			szl = {1'b0, level_now} + abst_pkg::LVL_W'(1);
		end
		bsel   = szl - abst_pkg::LVL_W'(1);
		sz_hit = (mis == '0) && (szl <= abst_pkg::LVL_W'(MAX_LEVEL)) && !offx[bsel[4:0]];
	end

	always_comb begin
		if (func == abst_pkg::FUNC_SIZE) begin
			dec.lvl = szl;
			dec.hit = sz_hit;
			dec.rej = 1'b0;
		end else begin
			dec.lvl = rep_lvl;
			dec.hit = !rep_rej;
			dec.rej = rep_rej;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/abst_calc.sv
// Update step: modify the level entry read from memory and form the result.
`default_nettype none

module abst_calc #(
	parameter int MIN_LEVEL = 12,
	parameter int MAX_LEVEL = 20,
	parameter int WINDOW    = 64,
	localparam int POS_W = $clog2(WINDOW),
	localparam int ENT_W = WINDOW + POS_W + abst_pkg::CNT_W + abst_pkg::SA_W
) (
	input  wire logic                        func,
	input  wire logic [abst_pkg::SIZE_W-1:0] size,
	input  wire logic                        failed,
	input  wire abst_pkg::dec_t              dec,
	input  wire logic [ENT_W-1:0]            rdata,
	input  wire logic [abst_pkg::CUR_W-1:0]  level_now,
	input  wire logic [abst_pkg::EL_W-1:0]   error_limit,
	input  wire logic [abst_pkg::PI_W-1:0]   probe_interval,
	output logic      [ENT_W-1:0]            wdata,
	output abst_pkg::res_t                   res
);

	logic [WINDOW-1:0]            win;
	logic [POS_W-1:0]             pos;
	logic [abst_pkg::CNT_W-1:0]   cnt;
	logic [abst_pkg::SA_W-1:0]    sa;
	logic [WINDOW-1:0]            win_nx;
	logic [POS_W-1:0]             pos_nx;
	logic [abst_pkg::CNT_W-1:0]   cnt_nx;
	logic                         was;
	logic [abst_pkg::SA_W:0]      cnt_sa;
	logic [abst_pkg::SA_W:0]      lim_sa;
	logic [abst_pkg::SA_W-1:0]    sa_nx;
	logic                         keep;
	logic [abst_pkg::LVL_W-1:0]   use_lvl;
	logic [abst_pkg::SIZE_W-1:0]  lim;

	assign win = rdata[WINDOW-1:0];
	assign pos = rdata[WINDOW +: POS_W];
	assign cnt = rdata[WINDOW + POS_W +: abst_pkg::CNT_W];
	assign sa  = rdata[WINDOW + POS_W + abst_pkg::CNT_W +: abst_pkg::SA_W];

	// failure window: replace the oldest bit and track the count
	always_comb begin
		was         = win[pos];
		win_nx      = win;
		win_nx[pos] = failed;
		pos_nx      = (pos == POS_W'(WINDOW - 1)) ? '0 : pos + POS_W'(1);
		if (was != failed) begin
			cnt_nx = failed ? cnt + abst_pkg::CNT_W'(1) : cnt - abst_pkg::CNT_W'(1);
		end else begin
			cnt_nx = cnt;
		end
	end

	// send attempts: wrap and probe on reaching the interval
	always_comb begin
		cnt_sa = {1'b0, sa} + (abst_pkg::SA_W + 1)'(1);
		lim_sa = (probe_interval == '0) ? {1'b1, {abst_pkg::SA_W{1'b0}}}
			: {1'b0, probe_interval};
		keep   = dec.hit && (cnt_sa >= lim_sa);
		sa_nx  = keep ? '0 : cnt_sa[abst_pkg::SA_W-1:0];
	end

	always_comb begin
		use_lvl = keep ? dec.lvl : dec.lvl - abst_pkg::LVL_W'(1);
		lim     = abst_pkg::SIZE_W'(1) << use_lvl[4:0];
	end

	always_comb begin
		res.wr         = 1'b0;
		res.level      = level_now;
		res.block_size = '0;
		res.rejected   = 1'b0;
		wdata          = rdata;
		if (func == abst_pkg::FUNC_SIZE) begin
			res.wr         = dec.hit;
			res.block_size = (size > lim) ? lim : size;
			wdata          = {sa_nx, cnt, pos, win};
		end else if (dec.rej) begin
			res.rejected = 1'b1;
		end else begin
			res.wr = 1'b1;
			wdata  = {sa, cnt_nx, pos_nx, win_nx};
			priority if (dec.lvl == {1'b0, level_now}
				&& level_now > abst_pkg::CUR_W'(MIN_LEVEL)
				&& cnt_nx > error_limit) begin
				res.level = level_now - abst_pkg::CUR_W'(1);
			end else if (dec.lvl == {1'b0, level_now} + abst_pkg::LVL_W'(1)
				&& !failed
				&& level_now < abst_pkg::CUR_W'(MAX_LEVEL)
				&& cnt_nx <= error_limit) begin
				res.level = dec.lvl[abst_pkg::CUR_W-1:0];
			end else begin
				res.level = level_now;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/adaptive_block_size_tuner.sv
// Top level of the adaptive block size tuner: control, registers, memory.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item: func=0
//   reports a transfer outcome (size, failed), func=1 asks for a block size
//   (size, offset_low). Every item yields exactly one result beat on the
//   output channel (out_valid/out_ready): current_level after the item,
//   block_size (zero for reports) and rejected (report size above the top
//   level; such a report changes nothing).
//   Per-level state (failure window, window position, error count, send
//   attempts) lives in one synchronous memory of MAX_LEVEL-MIN_LEVEL+1
//   entries. The accept edge reads an item's level entry; the update in the
//   busy state writes it back and loads the result register, so the block
//   takes no new item until the previous one has been written back. The
//   memory read-modify-write sets this limit. The result is valid once the update commits.
//   The result register parts the channels: a new item is taken while the
//   previous result still waits; its update then holds until that result
//   is taken, so a stalled receiver adds its stall cycles.
//   Reset (arst_n low) clears the level to START_LEVEL, both registers to
//   32 and every memory entry to zero at once through per-entry valid bits.
//   cfg_we writes error_limit (index 0) or probe_interval (index 1); the user
//   must write only while the block is idle, which the block does not enforce.
`default_nettype none

module adaptive_block_size_tuner #(
	parameter int MIN_LEVEL   = 12,
	parameter int MAX_LEVEL   = 20,
	parameter int START_LEVEL = 16,
	parameter int WINDOW      = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         func,
	input  wire logic [abst_pkg::SIZE_W-1:0]  size,
	input  wire logic                         failed,
	input  wire logic [abst_pkg::OFF_W-1:0]   offset_low,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [abst_pkg::CUR_W-1:0]   current_level,
	output logic      [abst_pkg::SIZE_W-1:0]  block_size,
	output logic                              rejected,
	input  wire logic                         cfg_we,
	input  wire logic [abst_pkg::CFG_AW-1:0]  cfg_index,
	input  wire logic [abst_pkg::CFG_W-1:0]   cfg_data
);

	localparam int DEPTH = MAX_LEVEL - MIN_LEVEL + 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W = $clog2(WINDOW);
	localparam int ENT_W = WINDOW + POS_W + abst_pkg::CNT_W + abst_pkg::SA_W;

	abst_pkg::state_t               state_q, state_nx;
	logic                           accept;
	logic                           done;
	logic                           commit;

	logic [abst_pkg::CUR_W-1:0]     level_q;
	logic [abst_pkg::EL_W-1:0]      error_limit_q;
	logic [abst_pkg::PI_W-1:0]      probe_interval_q;

	abst_pkg::dec_t                 dec;
	abst_pkg::dec_t                 dec_s1;
	logic                           func_s1;
	logic [abst_pkg::SIZE_W-1:0]    size_s1;
	logic                           failed_s1;

	logic [abst_pkg::LVL_W-1:0]     rd_off;
	logic [abst_pkg::LVL_W-1:0]     wr_off;
	logic [ENT_W-1:0]               rdata;
	logic [ENT_W-1:0]               wdata;
	abst_pkg::res_t                 res;

	logic                           out_valid_q;
	logic [abst_pkg::CUR_W-1:0]     current_level_q;
	logic [abst_pkg::SIZE_W-1:0]    block_size_q;
	logic                           rejected_q;

	// sequencer: accept in idle, update in busy once the result slot is free
	always_comb begin
		unique case (state_q)
			abst_pkg::ST_IDLE: state_nx = in_valid ? abst_pkg::ST_BUSY : abst_pkg::ST_IDLE;
			abst_pkg::ST_BUSY: state_nx = done ? abst_pkg::ST_IDLE : abst_pkg::ST_BUSY;
			default:           state_nx = abst_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		done = !out_valid_q || out_ready;
		unique case (state_q)
			abst_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				commit   = 1'b0;
			end
			abst_pkg::ST_BUSY: begin
				in_ready = 1'b0;
				commit   = done;
			end
			default: begin
				in_ready = 1'b0;
				commit   = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abst_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_limit_q    <= abst_pkg::ERROR_LIMIT_RST;
			probe_interval_q <= abst_pkg::PROBE_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (abst_pkg::cfg_reg_t'(cfg_index))
				abst_pkg::REG_ERROR_LIMIT:    error_limit_q    <= cfg_data[abst_pkg::EL_W-1:0];
				abst_pkg::REG_PROBE_INTERVAL: probe_interval_q <= cfg_data[abst_pkg::PI_W-1:0];
				default: ;
			endcase
		end
	end

	// pick the level ahead of the read so the memory address is ready at accept
	abst_decode #(
		.MIN_LEVEL (MIN_LEVEL),
		.MAX_LEVEL (MAX_LEVEL)
	) u_decode (
		.func       (func),
		.size       (size),
		.offset_low (offset_low),
		.level_now  (level_q),
		.dec        (dec)
	);

	// hold the item while its entry is read
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func;
			size_s1   <= size;
			failed_s1 <= failed;
			dec_s1    <= dec;
		end
	end

	assign rd_off = dec.lvl - abst_pkg::LVL_W'(MIN_LEVEL);
	assign wr_off = dec_s1.lvl - abst_pkg::LVL_W'(MIN_LEVEL);

	abst_mem #(
		.DEPTH (DEPTH),
		.WIDTH (ENT_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (commit && res.wr),
		.waddr  (wr_off[AW-1:0]),
		.wdata  (wdata),
		.re     (accept && dec.hit),
		.raddr  (rd_off[AW-1:0]),
		.rdata  (rdata)
	);

	abst_calc #(
		.MIN_LEVEL (MIN_LEVEL),
		.MAX_LEVEL (MAX_LEVEL),
		.WINDOW    (WINDOW)
	) u_calc (
		.func           (func_s1),
		.size           (size_s1),
		.failed         (failed_s1),
		.dec            (dec_s1),
		.rdata          (rdata),
		.level_now      (level_q),
		.error_limit    (error_limit_q),
		.probe_interval (probe_interval_q),
		.wdata          (wdata),
		.res            (res)
	);

	// current level changes only when an update commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= abst_pkg::CUR_W'(START_LEVEL);
		end else if (commit) begin
			level_q <= res.level;
		end
	end

	// result register: load on commit, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			current_level_q <= res.level;
			block_size_q    <= res.block_size;
			rejected_q      <= res.rejected;
		end
	end

	assign out_valid     = out_valid_q;
	assign current_level = current_level_q;
	assign block_size    = block_size_q;
	assign rejected      = rejected_q;

endmodule

`default_nettype wire

>>> rtl/core/abst_chk.sv
// Port-level checks of the adaptive block size tuner, bound to the top level.
`default_nettype none

module abst_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [abst_pkg::SIZE_W-1:0] block_size,
	input wire logic                        rejected
);

	// a result waiting for the receiver stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one item in flight: no beat taken right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a fresh result is loaded on the commit in the busy state that follows its accept
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a preceding accept");

	// a rejected report carries no block size
	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> block_size == '0)
		else $error("rejected result with nonzero block size");

endmodule

bind adaptive_block_size_tuner abst_chk u_abst_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.block_size (block_size),
	.rejected   (rejected)
);

`default_nettype wire

>>> sim/tb_adaptive_block_size_tuner.sv
// Testbench for the adaptive block size tuner: directed and random beats vs a local predictor.
`default_nettype none

module tb_adaptive_block_size_tuner;

	// block geometry, kept equal to the instance defaults
	localparam int MIN_LVL = 12;
	localparam int MAX_LVL = 20;
	localparam int START_LVL = 16;
	localparam int WIN = 64;
	localparam int NLVL = MAX_LVL - MIN_LVL + 1;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 800;

	// one result beat as the block should produce it
	typedef struct packed {
		logic [abst_pkg::CUR_W-1:0]  level;
		logic [abst_pkg::SIZE_W-1:0] bsize;
		logic                        rej;
	} tuner_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          func = abst_pkg::FUNC_REPORT;
	logic [abst_pkg::SIZE_W-1:0]   size = '0;
	logic                          failed = 1'b0;
	logic [abst_pkg::OFF_W-1:0]    offset_low = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [abst_pkg::CUR_W-1:0]    current_level;
	logic [abst_pkg::SIZE_W-1:0]   block_size;
	logic                          rejected;
	logic                          cfg_we = 1'b0;
	logic [abst_pkg::CFG_AW-1:0]   cfg_index = abst_pkg::REG_ERROR_LIMIT;
	logic [abst_pkg::CFG_W-1:0]    cfg_data = '0;

	adaptive_block_size_tuner uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.size(size),
		.failed(failed),
		.offset_low(offset_low),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.current_level(current_level),
		.block_size(block_size),
		.rejected(rejected),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor copy of the tuner state and its two registers
	int unsigned  lvl_now = START_LVL;
	logic [63:0]  hist_win [NLVL];
	int unsigned  hist_pos [NLVL];
	logic [6:0]   err_cnt [NLVL];
	int unsigned  probe_cnt [NLVL];
	logic [6:0]   err_lim = 7'd32;
	logic [15:0]  probe_ivl = 16'd32;

	tuner_result_t expected_q [$];
	tuner_result_t want;

	// idle rates in percent and the failure rate of random reports
	int unsigned src_idle_pct = 18;
	int unsigned sink_idle_pct = 64;
	int unsigned storm_pct = 50;

	// run statistics
	int unsigned mismatches = 0;
	int unsigned beats_checked = 0;
	int unsigned n_report = 0;
	int unsigned n_sized = 0;
	int unsigned n_rejected = 0;
	int unsigned n_probe = 0;
	int unsigned lvl_lo = START_LVL;
	int unsigned lvl_hi = START_LVL;
	int unsigned stall_cycles = 0;

	initial begin
		for (int i = 0; i < NLVL; i++) begin
			hist_win[i] = '0;
			hist_pos[i] = 0;
			err_cnt[i] = '0;
			probe_cnt[i] = 0;
		end
	end

	// offset bits past the port width read as zero
	function automatic logic off_bit(input logic [abst_pkg::OFF_W-1:0] off,
			input int unsigned b);
		return (b < abst_pkg::OFF_W) ? off[b] : 1'b0;
	endfunction

	// advance the predicted tuner state by one beat and return its result
	function automatic tuner_result_t predict_beat(input logic f,
			input logic [abst_pkg::SIZE_W-1:0] sz, input logic fl,
			input logic [abst_pkg::OFF_W-1:0] off);
		tuner_result_t r;
		int unsigned   lv;
		int unsigned   ix;
		int unsigned   cnt;
		int unsigned   ivl;
		logic [63:0]   bitm;
		logic          probe;
		logic [32:0]   cap;
		r = '0;
		probe = 1'b0;
		if (f == abst_pkg::FUNC_REPORT) begin
			n_report++;
			// map the size to the smallest level that holds it
			lv = MAX_LVL + 1;
			for (int l = MAX_LVL; l >= MIN_LVL; l--)
				if ({32'd0, sz} <= (64'd1 << l))
					lv = l;
			if (lv > MAX_LVL) begin
				r.rej = 1'b1;
				n_rejected++;
			end else begin
				ix = lv - MIN_LVL;
				bitm = 64'd1 << hist_pos[ix];
				hist_pos[ix] = (hist_pos[ix] + 1) % WIN;
				if (((hist_win[ix] & bitm) != 0) != fl) begin
					hist_win[ix] ^= bitm;
					err_cnt[ix] = fl ? err_cnt[ix] + 7'd1 : err_cnt[ix] - 7'd1;
				end
				if (lv == lvl_now && lvl_now > MIN_LVL && err_cnt[ix] > err_lim)
					lvl_now--;
				if (lv == lvl_now + 1 && !fl && lvl_now < MAX_LVL && err_cnt[ix] <= err_lim)
					lvl_now = lv;
			end
		end else begin
			n_sized++;
			// walk up while the offset stays aligned, capped one above the current level
			lv = MIN_LVL;
			while (lv <= lvl_now && !off_bit(off, lv - 1))
				lv++;
			if (lv <= MAX_LVL && !off_bit(off, lv - 1)) begin
				ix = lv - MIN_LVL;
				ivl = (probe_ivl == 0) ? 65536 : probe_ivl;
				cnt = probe_cnt[ix] + 1;
				if (cnt >= ivl) begin
					cnt = 0;
					probe = 1'b1;
					n_probe++;
				end
				probe_cnt[ix] = cnt & 16'hFFFF;
			end
			if (!probe)
				lv--;
			cap = 33'd1 << lv;
			r.bsize = ({1'b0, sz} > cap) ? cap[31:0] : sz;
		end
		r.level = lvl_now[abst_pkg::CUR_W-1:0];
		if (lvl_now < lvl_lo)
			lvl_lo = lvl_now;
		if (lvl_now > lvl_hi)
			lvl_hi = lvl_now;
		return r;
	endfunction

	// drive one beat at the falling edge, hold it until the accept edge
	task automatic send_item(input logic f, input logic [abst_pkg::SIZE_W-1:0] sz,
			input logic fl, input logic [abst_pkg::OFF_W-1:0] off);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		func = f;
		size = sz;
		failed = fl;
		offset_low = off;
		in_valid = 1'b1;
		expected_q.push_back(predict_beat(f, sz, fl, off));
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// drop valid and wait until every predicted result has been taken
	task automatic quiesce();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// write one register once the block has gone idle
	task automatic write_reg(input abst_pkg::cfg_reg_t idx,
			input logic [abst_pkg::CFG_W-1:0] val);
		quiesce();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == abst_pkg::REG_ERROR_LIMIT)
			err_lim = val[6:0];
		else
			probe_ivl = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// reported sizes on both sides of the lowest and the top level boundary, zero and oversized
	task automatic test_report_mapping();
		send_item(abst_pkg::FUNC_REPORT, 32'd0, 1'b0, '0);
		send_item(abst_pkg::FUNC_REPORT, 32'd4096, 1'b1, 20'hFFFFF);
		send_item(abst_pkg::FUNC_REPORT, 32'd4097, 1'b0, '0);
		send_item(abst_pkg::FUNC_REPORT, 32'h0010_0000, 1'b0, '0);
		send_item(abst_pkg::FUNC_REPORT, 32'h0010_0001, 1'b1, '0);
		send_item(abst_pkg::FUNC_REPORT, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF);
	endtask

	// offsets that cap the level: misaligned below the lowest level, partial, none
	task automatic test_size_alignment();
		send_item(abst_pkg::FUNC_SIZE, 32'hFFFF_FFFF, 1'b0, 20'h00800);
		send_item(abst_pkg::FUNC_SIZE, 32'd0, 1'b1, 20'hFFFFF);
		send_item(abst_pkg::FUNC_SIZE, 32'hFFFF_FFFF, 1'b0, 20'h80000);
		send_item(abst_pkg::FUNC_SIZE, 32'd1, 1'b0, 20'h08000);
	endtask

	// probe every send, a zero interval, and the widest interval
	task automatic test_probe();
		write_reg(abst_pkg::REG_PROBE_INTERVAL, 16'd1);
		send_item(abst_pkg::FUNC_SIZE, 32'hFFFF_FFFF, 1'b0, '0);
		write_reg(abst_pkg::REG_PROBE_INTERVAL, 16'd0);
		send_item(abst_pkg::FUNC_SIZE, 32'hFFFF_FFFF, 1'b0, '0);
		write_reg(abst_pkg::REG_PROBE_INTERVAL, 16'hFFFF);
		send_item(abst_pkg::FUNC_SIZE, 32'hFFFF_FFFF, 1'b0, '0);
	endtask

	// drop on one error, blocked rise, then climb to the top level
	task automatic test_level_moves();
		write_reg(abst_pkg::REG_ERROR_LIMIT, 16'd0);
		send_item(abst_pkg::FUNC_REPORT, 32'd1 << lvl_now, 1'b1, '0);
		send_item(abst_pkg::FUNC_REPORT, 32'd1 << (lvl_now + 1), 1'b0, '0);
		write_reg(abst_pkg::REG_ERROR_LIMIT, 16'd64);
		while (lvl_now < MAX_LVL)
			send_item(abst_pkg::FUNC_REPORT, 32'd1 << (lvl_now + 1), 1'b0, '0);
		// top level: the probe bit lies past the offset port
		send_item(abst_pkg::FUNC_SIZE, 32'hFFFF_FFFF, 1'b0, '0);
	endtask

	// one random beat, steered toward the current level and the one above
	task automatic random_item();
		int unsigned                 pick;
		int unsigned                 lv;
		int unsigned                 k;
		logic [abst_pkg::SIZE_W-1:0] sz;
		logic [abst_pkg::OFF_W-1:0]  off;
		logic                        fl;
		pick = $urandom_range(99);
		fl = ($urandom_range(99) < storm_pct);
		off = abst_pkg::OFF_W'($urandom);
		if (pick < 60) begin
			k = $urandom_range(99);
			if (k < 45)
				lv = lvl_now;
			else if (k < 70)
				lv = lvl_now + 1;
			else if (k < 90)
				lv = $urandom_range(MAX_LVL, MIN_LVL);
			else
				lv = 0;
			if (lv == 0)
				sz = $urandom_range(1) ? $urandom : $urandom_range(4096);
			else
				sz = $urandom_range(32'd1 << lv, (32'd1 << (lv - 1)) + 1);
			send_item(abst_pkg::FUNC_REPORT, sz, fl, off);
		end else begin
			sz = $urandom_range(1) ? $urandom : $urandom_range(32'h0020_0000);
			k = $urandom_range(20, 11);
			if ($urandom_range(1))
				off = off & ~((20'h1 << k) - 20'h1);
			send_item(abst_pkg::FUNC_SIZE, sz, 1'($urandom_range(1)), off);
		end
	endtask

	// random beats in four segments, each under its own register setting
	task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
			input int unsigned n);
		logic [abst_pkg::CFG_W-1:0] el;
		logic [abst_pkg::CFG_W-1:0] pi;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		for (int s = 0; s < 4; s++) begin
			case ($urandom_range(3))
				0: el = 16'd0;
				1: el = 16'd64;
				default: el = abst_pkg::CFG_W'($urandom_range(48, 8));
			endcase
			case ($urandom_range(3))
				0: pi = 16'd1;
				1: pi = 16'hFFFF;
				2: pi = abst_pkg::CFG_W'($urandom_range(8, 2));
				default: pi = abst_pkg::CFG_W'($urandom_range(40, 2));
			endcase
			write_reg(abst_pkg::REG_ERROR_LIMIT, el);
			write_reg(abst_pkg::REG_PROBE_INTERVAL, pi);
			for (int i = 0; i < n / 4; i++) begin
				// switch between calm stretches and error storms
				if (i % 40 == 0)
					case ($urandom_range(2))
						0: storm_pct = 10;
						1: storm_pct = 50;
						default: storm_pct = 85;
					endcase
				random_item();
			end
		end
	endtask

	// receiver stalls, redrawn every cycle
	always @(negedge clk)
		out_ready = ($urandom_range(99) >= sink_idle_pct);

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			beats_checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing expected: level %0d size %h rej %0d",
						$realtime, current_level, block_size, rejected);
			end else begin
				want = expected_q.pop_front();
				if (current_level !== want.level || block_size !== want.bsize ||
						rejected !== want.rej) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch: level %0d/%0d size %h/%h rej %0d/%0d (exp/got)",
							$realtime, want.level, current_level, want.bsize, block_size,
							want.rej, rejected);
				end
			end
		end
	end

	// end the run when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $realtime, STALL_LIMIT);
			$display("tb_adaptive_block_size_tuner: done, errors");
			$finish;
		end
	end

	initial begin
		// hold reset, then release it at a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_report_mapping();
		test_size_alignment();
		test_probe();
		test_level_moves();

		test_random_traffic(18, 64, RANDOM_ITEMS / 3);
		test_random_traffic(64, 18, RANDOM_ITEMS / 3);
		test_random_traffic(0, 0, RANDOM_ITEMS / 3);

		quiesce();
		repeat (8) @(negedge clk);

		$display("covered %0d result beats: %0d reports (%0d rejected), %0d size requests,",
			beats_checked, n_report, n_rejected, n_sized);
		$display("%0d probes, level range reached %0d..%0d, %0d mismatches",
			n_probe, lvl_lo, lvl_hi, mismatches);
		if (mismatches == 0)
			$display("tb_adaptive_block_size_tuner: done, clean");
		else
			$display("tb_adaptive_block_size_tuner: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/abst_pkg.sv
rtl/core/abst_mem.sv
rtl/core/abst_decode.sv
rtl/core/abst_calc.sv
rtl/core/adaptive_block_size_tuner.sv
rtl/core/abst_chk.sv
sim/tb_adaptive_block_size_tuner.sv
